FILE: rtl/usb_control_endpoint_responder_unit_macros.svh
// Assertion macros
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_UNIT_MACROS_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_UNIT_MACROS_SVH
`define UCER_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UCER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/ucer_pkg.sv
package ucer_pkg;
  localparam logic [1:0] OP_SETUP = 2'd0;
  localparam logic [1:0] OP_IN    = 2'd1;
  localparam logic [1:0] OP_OUT   = 2'd2;
  localparam logic [1:0] OP_BRST  = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_BYTE  = 3'd1;
  localparam logic [2:0] ACT_ZLP   = 3'd2;
  localparam logic [2:0] ACT_STALL = 3'd3;
  localparam logic [2:0] ACT_ADDR  = 3'd4;

  localparam logic [2:0] SRC_DEV  = 3'd0;
  localparam logic [2:0] SRC_CFG  = 3'd1;
  localparam logic [2:0] SRC_LANG = 3'd2;
  localparam logic [2:0] SRC_MANU = 3'd3;
  localparam logic [2:0] SRC_PROD = 3'd4;
  localparam logic [2:0] SRC_CVAL = 3'd5;
  localparam logic [2:0] SRC_ZERO = 3'd6;
  localparam logic [2:0] SRC_LINE = 3'd7;

  localparam logic [55:0] LINE_RESET = 56'h08_0000_0001_C200;
  localparam logic [15:0] VID_RESET  = 16'h1D50;
  localparam logic [15:0] PID_RESET  = 16'h6019;

  localparam logic [7:0] REQ_GET_LINE = 8'h21;
  localparam logic [7:0] REQ_SET_LINE = 8'h20;
  localparam logic [7:0] REQ_SET_CTRL = 8'h22;

  localparam logic       CFG_IDX_VID = 1'b0;
  localparam logic       CFG_IDX_PID = 1'b1;

  // datapath command from controller
  typedef struct packed {
    logic       load;    // latch new item and run decode
    logic       emit;    // emit current byte, advance
  } ucer_cmd_t;

  typedef struct packed {
    logic       busy_bytes; // bytes left in this packet
    logic       last_byte;  // current byte is last of packet
  } ucer_sts_t;

  function automatic logic [7:0] rom_static(input logic [2:0] src, input logic [6:0] off);
    logic [7:0] b;
    b = 8'd0;
    case (src)
      SRC_CFG: begin
        case (off)
          7'd0: b = 8'd9;  7'd1: b = 8'd2;  7'd2: b = 8'd67; 7'd3: b = 8'd0;
          7'd4: b = 8'd2;  7'd5: b = 8'd1;  7'd6: b = 8'd0;  7'd7: b = 8'h80;
          7'd8: b = 8'd250;
          7'd9: b = 8'd9;  7'd10: b = 8'd4; 7'd11: b = 8'd0; 7'd12: b = 8'd0;
          7'd13: b = 8'd1; 7'd14: b = 8'h02; 7'd15: b = 8'h02; 7'd16: b = 8'h01;
          7'd17: b = 8'd0;
          7'd18: b = 8'd5; 7'd19: b = 8'h24; 7'd20: b = 8'h00; 7'd21: b = 8'h10;
          7'd22: b = 8'h01;
          7'd23: b = 8'd5; 7'd24: b = 8'h24; 7'd25: b = 8'h01; 7'd26: b = 8'h00;
          7'd27: b = 8'd1;
          7'd28: b = 8'd4; 7'd29: b = 8'h24; 7'd30: b = 8'h02; 7'd31: b = 8'h02;
          7'd32: b = 8'd5; 7'd33: b = 8'h24; 7'd34: b = 8'h06; 7'd35: b = 8'd0;
          7'd36: b = 8'd1;
          7'd37: b = 8'd7; 7'd38: b = 8'd5; 7'd39: b = 8'h83; 7'd40: b = 8'h03;
          7'd41: b = 8'd16; 7'd42: b = 8'd0; 7'd43: b = 8'hFF;
          7'd44: b = 8'd9; 7'd45: b = 8'd4; 7'd46: b = 8'd1; 7'd47: b = 8'd0;
          7'd48: b = 8'd2; 7'd49: b = 8'h0A; 7'd50: b = 8'd0; 7'd51: b = 8'd0;
          7'd52: b = 8'd0;
          7'd53: b = 8'd7; 7'd54: b = 8'd5; 7'd55: b = 8'h01; 7'd56: b = 8'h02;
          7'd57: b = 8'd64; 7'd58: b = 8'd0; 7'd59: b = 8'd0;
          7'd60: b = 8'd7; 7'd61: b = 8'd5; 7'd62: b = 8'h82; 7'd63: b = 8'h02;
          7'd64: b = 8'd64; 7'd65: b = 8'd0; 7'd66: b = 8'd0;
          default: b = 8'd0;
        endcase
      end
      SRC_LANG: begin
        case (off)
          7'd0: b = 8'd4; 7'd1: b = 8'd3; 7'd2: b = 8'h09; 7'd3: b = 8'h04;
          default: b = 8'd0;
        endcase
      end
      SRC_MANU: begin
        case (off)
          7'd0: b = 8'd14; 7'd1: b = 8'd3; 7'd2: b = 8'h4D; 7'd4: b = 8'h61;
          7'd6: b = 8'h72; 7'd8: b = 8'h6C; 7'd10: b = 8'h69; 7'd12: b = 8'h6E;
          default: b = 8'd0;
        endcase
      end
      SRC_PROD: begin
        case (off)
          7'd0: b = 8'd8; 7'd1: b = 8'd3; 7'd2: b = 8'h34; 7'd4: b = 8'h70;
          7'd6: b = 8'h69;
          default: b = 8'd0;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction
endpackage

FILE: rtl/usb_control_endpoint_responder_unit.sv
// The first result is presented in the cycle after an item is accepted.
// Throughput: one result per cycle while out_stall_i is low.
// The next item is taken once the last result of the current one is taken.
// Reset (rst_ni low, async) clears state, IDs to defaults, line coding 115200 8N1.
module usb_control_endpoint_responder_unit
  import ucer_pkg::*;
#(
  parameter int PACKET_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_length_i,
  input  logic [6:0]  out_count_i,
  input  logic [55:0] out_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        configured_o,
  output logic        host_open_o
);
  ucer_cmd_t cmd;
  ucer_sts_t sts;

  ucer_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ucer_datapath #(.PACKET_BYTES(PACKET_BYTES)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cmd_i(cmd), .sts_o(sts),
    .op_i, .request_type_i, .request_code_i, .request_value_i, .request_length_i,
    .out_count_i, .out_bytes_i, .action_o, .data_byte_o, .last_o,
    .device_address_o, .configured_o, .host_open_o
  );
endmodule

FILE: rtl/ucer_datapath.sv
module ucer_datapath
  import ucer_pkg::*;
#(
  parameter int PACKET_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  ucer_cmd_t   cmd_i,
  output ucer_sts_t   sts_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_length_i,
  input  logic [6:0]  out_count_i,
  input  logic [55:0] out_bytes_i,
  output logic [2:0]  action_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        configured_o,
  output logic        host_open_o
);
  localparam logic [6:0] PKT = 7'(PACKET_BYTES);

  logic [15:0] vid_q, pid_q;
  logic [6:0]  addr_q, addr_d;
  logic        cfgd_q, cfgd_d, dtr_q, dtr_d;
  logic [55:0] line_q, line_d;
  logic [2:0]  src_q, src_d;
  logic [6:0]  off_q, off_d, rem_q, rem_d;
  logic        zlp_q, zlp_d, awt_q, awt_d;
  logic [6:0]  cnt_q, cnt_d;     // bytes left in current packet
  logic [2:0]  act_q, act_d;     // single result action when cnt is zero
  logic [6:0]  raddr_q, raddr_d;

  // decode helpers
  logic        start;
  logic [2:0]  s_src;
  logic [6:0]  s_size;
  logic [16:0] len;
  logic [6:0]  n;
  logic        mult;           // len is a whole number of packets
  logic [7:0]  byte_val;
  logic [7:0]  dev_b;

  always_comb begin
    addr_d = addr_q; cfgd_d = cfgd_q; dtr_d = dtr_q; line_d = line_q;
    src_d = src_q; off_d = off_q; rem_d = rem_q; zlp_d = zlp_q; awt_d = awt_q;
    cnt_d = cnt_q; act_d = act_q; raddr_d = 7'd0;
    start = 1'b0; s_src = SRC_DEV; s_size = 7'd0;
    len = 17'd0; n = 7'd0; mult = 1'b0;
    if (cmd_i.load) begin
      act_d = ACT_NONE; cnt_d = 7'd0;
      case (op_i)
        OP_SETUP: begin
          src_d = SRC_DEV; off_d = 7'd0; rem_d = 7'd0; zlp_d = 1'b0; awt_d = 1'b0;
          case (request_type_i[6:5])
            2'd0: begin
              case (request_code_i)
                8'd6: begin
                  act_d = ACT_STALL;
                  case (request_value_i[15:8])
                    8'd1: begin start = 1'b1; s_src = SRC_DEV; s_size = 7'd18; end
                    8'd2: begin start = 1'b1; s_src = SRC_CFG; s_size = 7'd67; end
                    8'd3: begin
                      case (request_value_i[7:0])
                        8'd0: begin start = 1'b1; s_src = SRC_LANG; s_size = 7'd4; end
                        8'd1: begin start = 1'b1; s_src = SRC_MANU; s_size = 7'd14; end
                        8'd2: begin start = 1'b1; s_src = SRC_PROD; s_size = 7'd8; end
                        default: ;
                      endcase
                    end
                    default: ;
                  endcase
                end
                8'd5: begin addr_d = request_value_i[6:0]; act_d = ACT_ZLP; end
                8'd9: begin cfgd_d = |request_value_i[7:0]; act_d = ACT_ZLP; end
                8'd8: begin start = 1'b1; s_src = SRC_CVAL; s_size = 7'd1; end
                8'd0: begin start = 1'b1; s_src = SRC_ZERO; s_size = 7'd2; end
                8'd10: begin start = 1'b1; s_src = SRC_ZERO; s_size = 7'd1; end
                8'd1, 8'd3, 8'd11: act_d = ACT_ZLP;
                default: act_d = ACT_STALL;
              endcase
            end
            2'd1: begin
              case (request_code_i)
                REQ_GET_LINE: begin start = 1'b1; s_src = SRC_LINE; s_size = 7'd7; end
                REQ_SET_LINE: awt_d = 1'b1;
                REQ_SET_CTRL: begin dtr_d = request_value_i[0]; act_d = ACT_ZLP; end
                default: act_d = ACT_STALL;
              endcase
            end
            default: act_d = ACT_STALL;
          endcase
          if (start) begin
            len = (17'(s_size) < 17'(request_length_i)) ? 17'(s_size)
                                                         : 17'(request_length_i);
            for (int k = 1; k * PACKET_BYTES < 128; k++)
              if (int'(len[6:0]) == k * PACKET_BYTES) mult = 1'b1;
            src_d = s_src;
            rem_d = len[6:0];
            zlp_d = (len < 17'(request_length_i)) && mult && (len != 17'd0);
            n = (len[6:0] > PKT) ? PKT : len[6:0];
            cnt_d = n;
            if (n < PKT && len[6:0] == n) zlp_d = 1'b0;
            act_d = (n == 7'd0) ? ACT_ZLP : ACT_NONE;
            off_d = 7'd0;
            rem_d = len[6:0] - n;
          end
        end
        OP_IN: begin
          if (rem_q != 7'd0 || zlp_q) begin
            if (rem_q == 7'd0) zlp_d = 1'b0;
            n = (rem_q > PKT) ? PKT : rem_q;
            cnt_d = n;
            rem_d = rem_q - n;
            if (rem_d == 7'd0 && n < PKT) zlp_d = 1'b0;
            act_d = (n == 7'd0) ? ACT_ZLP : ACT_NONE;
          end else if (addr_q != 7'd0) begin
            act_d = ACT_ADDR; addr_d = 7'd0;
          end
        end
        OP_OUT: begin
          if (awt_q) begin
            for (int j = 0; j < 7; j++)
              if (7'(j) < out_count_i) line_d[8*j +: 8] = out_bytes_i[8*j +: 8];
            awt_d = 1'b0; src_d = SRC_DEV; off_d = 7'd0; rem_d = 7'd0; zlp_d = 1'b0;
            act_d = ACT_ZLP;
          end
        end
        default: begin
          cfgd_d = 1'b0; dtr_d = 1'b0; addr_d = 7'd0; src_d = SRC_DEV;
          off_d = 7'd0; rem_d = 7'd0; zlp_d = 1'b0; awt_d = 1'b0;
        end
      endcase
      raddr_d = addr_q;
    end else if (cmd_i.emit) begin
      cnt_d = cnt_q - 7'd1;
      off_d = off_q + 7'd1;
    end
  end

  always_comb begin
    dev_b = 8'd0;
    case (off_q)
      7'd0: dev_b = 8'd18; 7'd1: dev_b = 8'd1; 7'd3: dev_b = 8'h02; 7'd4: dev_b = 8'h02;
      7'd7: dev_b = 8'(PACKET_BYTES);
      7'd8: dev_b = vid_q[7:0]; 7'd9: dev_b = vid_q[15:8];
      7'd10: dev_b = pid_q[7:0]; 7'd11: dev_b = pid_q[15:8];
      7'd13: dev_b = 8'h01; 7'd14: dev_b = 8'd1; 7'd15: dev_b = 8'd2;
      7'd17: dev_b = 8'd1;
      default: dev_b = 8'd0;
    endcase
    case (src_q)
      SRC_DEV:  byte_val = dev_b;
      SRC_CVAL: byte_val = (off_q == 7'd0) ? {7'd0, cfgd_q} : 8'd0;
      SRC_LINE: byte_val = (off_q < 7'd7) ? line_q[{off_q[2:0], 3'b000} +: 8] : 8'd0;
      default:  byte_val = rom_static(src_q, off_q);
    endcase
  end

  assign sts_o.busy_bytes = (cnt_q != 7'd0);
  assign sts_o.last_byte  = (cnt_q == 7'd1);

  assign action_o         = (cnt_q != 7'd0) ? ACT_BYTE : act_q;
  assign data_byte_o      = (cnt_q != 7'd0) ? byte_val : 8'd0;
  assign last_o           = (cnt_q <= 7'd1);
  assign device_address_o = (cnt_q == 7'd0 && act_q == ACT_ADDR) ? raddr_q : 7'd0;
  assign configured_o     = cfgd_q;
  assign host_open_o      = dtr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_q <= VID_RESET; pid_q <= PID_RESET;
      addr_q <= 7'd0; cfgd_q <= 1'b0; dtr_q <= 1'b0; line_q <= LINE_RESET;
      src_q <= SRC_DEV; off_q <= 7'd0; rem_q <= 7'd0; zlp_q <= 1'b0; awt_q <= 1'b0;
      cnt_q <= 7'd0; act_q <= ACT_NONE; raddr_q <= 7'd0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IDX_VID) vid_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_IDX_PID) pid_q <= cfg_data_i;
      addr_q <= addr_d; cfgd_q <= cfgd_d; dtr_q <= dtr_d; line_q <= line_d;
      src_q <= src_d; off_q <= off_d; rem_q <= rem_d; zlp_q <= zlp_d; awt_q <= awt_d;
      cnt_q <= cnt_d; act_q <= act_d;
      if (cmd_i.load) raddr_q <= raddr_d;
    end
  end
endmodule

FILE: rtl/ucer_ctrl.sv
module ucer_ctrl
  import ucer_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ucer_sts_t sts_i,
  output ucer_cmd_t cmd_o
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_OUT  = 1'b1;
  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; state_d = ST_OUT;
      end
      ST_OUT: if (!out_stall_i) begin
        if (sts_i.busy_bytes && !sts_i.last_byte) cmd_o.emit = 1'b1;
        else begin
          cmd_o.emit = sts_i.busy_bytes; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule

FILE: rtl/ucer_checker.sv
`include "usb_control_endpoint_responder_unit_macros.svh"
module ucer_checker
  import ucer_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [7:0] data_byte_o,
  input logic       last_o,
  input logic [6:0] device_address_o
);
  `UCER_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, in_stall_o)
  `UCER_ASSERT_IMP(a_addr_only, clk_i, rst_ni, out_valid_o && action_o != ACT_ADDR,
    device_address_o == 7'd0)
  `UCER_ASSERT_IMP(a_byte_only, clk_i, rst_ni, out_valid_o && action_o != ACT_BYTE,
    data_byte_o == 8'd0 && last_o)
  `UCER_ASSERT_NEXT(a_accept_out, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
endmodule

bind usb_control_endpoint_responder_unit ucer_checker u_chk (.*);

FILE: tb/usb_control_endpoint_responder_unit_test.sv
`timescale 1ns / 100ps

module usb_control_endpoint_responder_unit_test;
  import ucer_pkg::*;

  localparam int PKT = 64;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] device_address;
    logic       configured;
    logic       host_open;
  } ep_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] length;
    logic [6:0]  cnt;
    logic [55:0] bytes;
  } ep_event_t;

  class ep0_scoreboard;
    logic [15:0] vid, pid;
    logic [6:0]  parked;
    logic        cfgd, dtr;
    logic [55:0] line;
    logic [2:0]  src;
    logic [6:0]  offs, remain;
    logic        zlp_due, want_out;
    ep_result_t  pending[$];
    int          errors;

    function void clear();
      vid = VID_RESET; pid = PID_RESET; parked = '0; cfgd = 0; dtr = 0;
      line = LINE_RESET; src = SRC_DEV; offs = '0; remain = '0;
      zlp_due = 0; want_out = 0; pending.delete(); errors = 0;
    endfunction

    function logic [7:0] desc_byte(logic [2:0] s, int o);
      logic [7:0] dev[18];
      dev = '{8'd18, 8'd1, 8'h00, 8'h02, 8'h02, 8'd0, 8'd0, 8'(PKT),
              vid[7:0], vid[15:8], pid[7:0], pid[15:8], 8'h00, 8'h01, 8'd1, 8'd2,
              8'd0, 8'd1};
      case (s)
        SRC_DEV: return o < 18 ? dev[o] : 8'd0;
        SRC_CFG: return o < 67 ? rom_byte_cfg(o) : 8'd0;
        SRC_LANG: return o < 4 ? lang_byte(o) : 8'd0;
        SRC_MANU: return o < 14 ? manu_byte(o) : 8'd0;
        SRC_PROD: return o < 8 ? prod_byte(o) : 8'd0;
        SRC_CVAL: return (o == 0) ? {7'd0, cfgd} : 8'd0;
        SRC_LINE: return o < 7 ? line[8*o +: 8] : 8'd0;
        default: return 8'd0;
      endcase
    endfunction

    function logic [7:0] lang_byte(int o);
      logic [7:0] t[4];
      t = '{8'd4, 8'd3, 8'h09, 8'h04};
      return t[o];
    endfunction

    function logic [7:0] manu_byte(int o);
      int t[14];
      t = '{14, 3, 'h4D, 0, 'h61, 0, 'h72, 0, 'h6C, 0, 'h69, 0, 'h6E, 0};
      return 8'(t[o]);
    endfunction

    function logic [7:0] prod_byte(int o);
      int t[8];
      t = '{8, 3, 'h34, 0, 'h70, 0, 'h69, 0};
      return 8'(t[o]);
    endfunction

    function logic [7:0] rom_byte_cfg(int o);
      int t[67];
      t = '{9, 2, 67, 0, 2, 1, 0, 'h80, 250,
            9, 4, 0, 0, 1, 2, 2, 1, 0,
            5, 'h24, 0, 'h10, 1,
            5, 'h24, 1, 0, 1,
            4, 'h24, 2, 2,
            5, 'h24, 6, 0, 1,
            7, 5, 'h83, 3, 16, 0, 'hFF,
            9, 4, 1, 0, 2, 'h0A, 0, 0, 0,
            7, 5, 1, 2, 64, 0, 0,
            7, 5, 'h82, 2, 64, 0, 0};
      return 8'(t[o]);
    endfunction

    function void push(logic [2:0] a, logic [7:0] b, logic [6:0] adr);
      ep_result_t r;
      r = '0; r.action = a; r.data_byte = b; r.device_address = adr;
      pending.push_back(r);
    endfunction

    function void send_packet();
      int n;
      n = remain > PKT ? PKT : remain;
      for (int i = 0; i < n; i++) push(ACT_BYTE, desc_byte(src, offs + i), '0);
      offs = 7'(offs + n);
      remain = 7'(remain - n);
      if (remain == 0 && n < PKT) zlp_due = 0;
      if (n == 0) push(ACT_ZLP, '0, '0);
    endfunction

    function void start_reply(logic [2:0] s, int size, int wlen);
      int len;
      len = size < wlen ? size : wlen;
      src = s; offs = '0; remain = 7'(len);
      zlp_due = len < wlen && (len % PKT) == 0 && len != 0;
      send_packet();
    endfunction

    function void note_event(ep_event_t e);
      int first;
      first = pending.size();
      case (e.op)
        OP_SETUP: begin
          src = SRC_DEV; offs = '0; remain = '0; zlp_due = 0; want_out = 0;
          if (e.rtype[6:5] == 2'd0) begin
            case (e.code)
              8'd6: begin
                if (e.value[15:8] == 8'd1) start_reply(SRC_DEV, 18, e.length);
                else if (e.value[15:8] == 8'd2) start_reply(SRC_CFG, 67, e.length);
                else if (e.value[15:8] == 8'd3 && e.value[7:0] == 8'd0)
                  start_reply(SRC_LANG, 4, e.length);
                else if (e.value[15:8] == 8'd3 && e.value[7:0] == 8'd1)
                  start_reply(SRC_MANU, 14, e.length);
                else if (e.value[15:8] == 8'd3 && e.value[7:0] == 8'd2)
                  start_reply(SRC_PROD, 8, e.length);
                else push(ACT_STALL, '0, '0);
              end
              8'd5: begin parked = e.value[6:0]; push(ACT_ZLP, '0, '0); end
              8'd9: begin cfgd = e.value[7:0] != 0; push(ACT_ZLP, '0, '0); end
              8'd8: start_reply(SRC_CVAL, 1, e.length);
              8'd0: start_reply(SRC_ZERO, 2, e.length);
              8'd10: start_reply(SRC_ZERO, 1, e.length);
              8'd1, 8'd3, 8'd11: push(ACT_ZLP, '0, '0);
              default: push(ACT_STALL, '0, '0);
            endcase
          end else if (e.rtype[6:5] == 2'd1) begin
            case (e.code)
              REQ_GET_LINE: start_reply(SRC_LINE, 7, e.length);
              REQ_SET_LINE: want_out = 1;
              REQ_SET_CTRL: begin dtr = e.value[0]; push(ACT_ZLP, '0, '0); end
              default: push(ACT_STALL, '0, '0);
            endcase
          end else push(ACT_STALL, '0, '0);
        end
        OP_IN: begin
          if (remain != 0 || zlp_due) begin
            if (remain == 0) zlp_due = 0;
            send_packet();
          end else if (parked != 0) begin
            push(ACT_ADDR, '0, parked);
            parked = '0;
          end
        end
        OP_OUT: begin
          if (want_out) begin
            for (int j = 0; j < 7; j++)
              if (j < e.cnt) line[8*j +: 8] = e.bytes[8*j +: 8];
            want_out = 0; src = SRC_DEV; offs = '0; remain = '0; zlp_due = 0;
            push(ACT_ZLP, '0, '0);
          end
        end
        default: begin
          cfgd = 0; dtr = 0; parked = '0; src = SRC_DEV; offs = '0; remain = '0;
          zlp_due = 0; want_out = 0;
        end
      endcase
      if (pending.size() == first) push(ACT_NONE, '0, '0);
      for (int i = first; i < pending.size(); i++) begin
        pending[i].configured = cfgd;
        pending[i].host_open = dtr;
      end
      pending[pending.size() - 1].last = 1;
    endfunction

    function void check_result(ep_result_t got);
      ep_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result action=%0d", got.action);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.action !== want.action) begin
        $error("action exp %0d got %0d", want.action, got.action); errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte exp %0h got %0h", want.data_byte, got.data_byte); errors++;
      end
      if (got.last !== want.last) begin
        $error("last exp %0d got %0d", want.last, got.last); errors++;
      end
      if (got.device_address !== want.device_address) begin
        $error("device_address exp %0d got %0d", want.device_address,
               got.device_address);
        errors++;
      end
      if (got.configured !== want.configured) begin
        $error("configured exp %0d got %0d", want.configured, got.configured); errors++;
      end
      if (got.host_open !== want.host_open) begin
        $error("host_open exp %0d got %0d", want.host_open, got.host_open); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_code_i = '0;
  logic [15:0] request_value_i = '0;
  logic [15:0] request_length_i = '0;
  logic [6:0]  out_count_i = '0;
  logic [55:0] out_bytes_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  action_o;
  logic [7:0]  data_byte_o;
  logic        last_o;
  logic [6:0]  device_address_o;
  logic        configured_o;
  logic        host_open_o;

  usb_control_endpoint_responder_unit DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  ep0_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_event({op_i, request_type_i, request_code_i, request_value_i,
                       request_length_i, out_count_i, out_bytes_i});
      if (out_valid_o && !out_stall_i)
        sb.check_result({action_o, data_byte_o, last_o, device_address_o,
                         configured_o, host_open_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_event(ep_event_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= e.op; request_type_i <= e.rtype; request_code_i <= e.code;
    request_value_i <= e.value; request_length_i <= e.length;
    out_count_i <= e.cnt; out_bytes_i <= e.bytes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic setup_req(logic [7:0] t, logic [7:0] c, logic [15:0] v,
                           logic [15:0] l);
    ep_event_t e;
    e = {OP_SETUP, t, c, v, l, 7'($urandom), 56'({$urandom, $urandom})};
    send_event(e);
  endtask

  task automatic simple_op(logic [1:0] op, logic [6:0] n, logic [55:0] b);
    ep_event_t e;
    e = {op, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), n, b};
    send_event(e);
  endtask

  task automatic drain_and_write(logic idx, logic [15:0] val);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_IDX_VID) sb.vid = val; else sb.pid = val;
  endtask

  task automatic random_event();
    int k;
    logic [15:0] v, l;
    k = $urandom_range(99);
    l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(140));
    if (k < 40) begin
      case ($urandom_range(4))
        0: v = 16'h0100;
        1: v = 16'h0200;
        2: v = {8'h03, 8'($urandom_range(3))};
        3: v = 16'($urandom);
        default: v = {8'($urandom_range(4)), 8'($urandom_range(3))};
      endcase
      setup_req({1'($urandom), 2'b00, 5'($urandom)}, 8'd6, v, l);
    end else if (k < 55) begin
      setup_req({1'($urandom), 2'b00, 5'($urandom)}, 8'($urandom_range(12)),
                16'($urandom), l);
    end else if (k < 65) begin
      setup_req({1'($urandom), 2'b01, 5'($urandom)},
                8'(REQ_SET_LINE + $urandom_range(3)), 16'($urandom), l);
    end else if (k < 85) begin
      simple_op(OP_IN, 7'($urandom), 56'({$urandom, $urandom}));
    end else if (k < 92) begin
      simple_op(OP_OUT, 7'($urandom_range(127)), 56'({$urandom, $urandom}));
    end else if (k < 96) begin
      setup_req(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      simple_op(OP_BRST, 7'($urandom), 56'({$urandom, $urandom}));
    end
  endtask

  initial begin
    sb.clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    setup_req(8'h80, 8'd6, 16'h0100, 16'hFFFF);
    setup_req(8'h80, 8'd6, 16'h0200, 16'd67);
    simple_op(OP_IN, 7'd0, '0);
    setup_req(8'h80, 8'd6, 16'h0200, 16'd128);
    simple_op(OP_IN, 7'd0, '0);
    simple_op(OP_IN, 7'd0, '0);
    setup_req(8'h80, 8'd6, 16'h0200, 16'd64);
    simple_op(OP_IN, 7'd0, '0);
    setup_req(8'h80, 8'd6, 16'h0301, 16'd0);
    setup_req(8'h80, 8'd6, 16'h0302, 16'd200);
    setup_req(8'h80, 8'd6, 16'h0303, 16'd8);
    setup_req(8'h00, 8'd5, 16'h007F, 16'd0);
    simple_op(OP_IN, 7'd0, '0);
    setup_req(8'h00, 8'd5, 16'h0000, 16'd0);
    simple_op(OP_IN, 7'd0, '0);
    setup_req(8'h00, 8'd9, 16'hFF00, 16'd0);
    setup_req(8'h00, 8'd9, 16'h0080, 16'd0);
    setup_req(8'h80, 8'd8, 16'h0000, 16'd1);
    setup_req(8'h21, REQ_SET_LINE, 16'h0000, 16'd7);
    simple_op(OP_OUT, 7'd127, 56'hFF_FFFF_FFFF_FFFF);
    simple_op(OP_OUT, 7'd3, '0);
    setup_req(8'hA1, REQ_GET_LINE, 16'h0000, 16'd7);
    setup_req(8'h21, REQ_SET_CTRL, 16'hFFFF, 16'd0);
    setup_req(8'h40, 8'd6, 16'h0100, 16'd18);
    simple_op(OP_BRST, 7'd0, '0);

    drain_and_write(CFG_IDX_VID, 16'hFFFF);
    drain_and_write(CFG_IDX_PID, 16'h0000);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < 90; i++) random_event();
      case (ph)
        0: begin
          drain_and_write(CFG_IDX_VID, 16'h0000);
          drain_and_write(CFG_IDX_PID, 16'hFFFF);
        end
        1: begin
          drain_and_write(CFG_IDX_VID, 16'($urandom));
          drain_and_write(CFG_IDX_PID, 16'($urandom));
        end
        default: ;
      endcase
    end

    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/ucer_pkg.sv
rtl/ucer_datapath.sv
rtl/ucer_ctrl.sv
rtl/usb_control_endpoint_responder_unit.sv
rtl/ucer_checker.sv
tb/usb_control_endpoint_responder_unit_test.sv
